// File: rtl/image_rotate_quarter_turns_macros.svh
// Assertion macros shared by the quarter-turn rotator's RTL.
`ifndef IMAGE_ROTATE_QUARTER_TURNS_MACROS_SVH
`define IMAGE_ROTATE_QUARTER_TURNS_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define IRQT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irqt: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define IRQT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irqt: next-cycle check failed");

`endif

// File: rtl/irqt_pkg.sv
// Types, constants and helper functions of the quarter-turn rotator.
package irqt_pkg;

  // Frame store geometry and pixel width.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXEL_BITS = 24;

  // Fixed widths of the channel fields and configuration port.
  localparam int FIELD_W   = 24;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // Derived widths.
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);
  localparam int OPA_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int OPB_W     = (WID_W > HGT_W) ? WID_W : HGT_W;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int BANK_AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int STORE_AW  = BANK_AW + 1;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;

  typedef logic [FIELD_W-1:0]    field_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [CFG_W-1:0]      cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [1:0]            turns_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [WID_W-1:0]      width_t;
  typedef logic [HGT_W-1:0]      height_t;
  typedef logic [OPA_W-1:0]      opa_t;
  typedef logic [OPB_W-1:0]      opb_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [BANK_AW-1:0]    bank_addr_t;
  typedef logic [STORE_AW-1:0]   store_addr_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_TURNS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_WIDTH  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_HEIGHT = cfg_idx_t'(2);

  // Rotation codes.
  localparam turns_t TURN_0   = turns_t'(0);
  localparam turns_t TURN_90  = turns_t'(1);
  localparam turns_t TURN_180 = turns_t'(2);
  localparam turns_t TURN_270 = turns_t'(3);

  // Geometry after reset, limited to the store size.
  localparam width_t  WIDTH_RST  = width_t'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
  localparam height_t HEIGHT_RST = height_t'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

  // Write request into the frame store.
  typedef struct packed {
    logic        en;
    store_addr_t addr;
    pixel_t      data;
  } wr_req_t;

  // Status of the item being accepted, plus the current bank.
  typedef struct packed {
    logic frame_ready;
    logic last;
    logic write_bank;
  } step_t;

  // A width of zero becomes one, anything above the store limit becomes the limit.
  function automatic width_t clamp_width(input cfg_data_t v);
    if (v == '0) begin
      return width_t'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      return width_t'(MAX_WIDTH);
    end else begin
      return width_t'(v);
    end
  endfunction

  function automatic height_t clamp_height(input cfg_data_t v);
    if (v == '0) begin
      return height_t'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      return height_t'(MAX_HEIGHT);
    end else begin
      return height_t'(v);
    end
  endfunction

endpackage

// File: rtl/irqt_if.sv
// Valid/ready channel interfaces for incoming pixels and rotated results.
interface irqt_in_if;
  logic             valid;
  logic             ready;
  irqt_pkg::field_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface irqt_out_if;
  logic             valid;
  logic             ready;
  irqt_pkg::field_t pixel_out;
  logic             out_valid;
  logic             frame_end;

  modport source (output valid, output pixel_out, output out_valid, output frame_end,
                  input ready);
  modport sink (input valid, input pixel_out, input out_valid, input frame_end,
                output ready);
endinterface

// File: rtl/irqt_frame_ram.sv
// Ping-pong frame store: one write port, one registered read port with bypass.
module irqt_frame_ram (
  input  logic                  clk,
  input  irqt_pkg::wr_req_t     wr,
  input  logic                  rd_en,
  input  irqt_pkg::store_addr_t rd_addr,
  output irqt_pkg::pixel_t      rd_data
);

  irqt_pkg::pixel_t mem [irqt_pkg::STORE_DEPTH];
  irqt_pkg::pixel_t rd_data_r;

  // Scatter write of the rotated pixel.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Sequential read; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/irqt_addr_gen.sv
// Raster counters, read index and two-stage rotated write address pipeline.
module irqt_addr_gen (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  irqt_pkg::pixel_t      pixel,
  input  irqt_pkg::turns_t      turns,
  input  irqt_pkg::width_t      width,
  input  irqt_pkg::height_t     height,
  input  logic                  geom_clear,
  output irqt_pkg::store_addr_t rd_addr,
  output irqt_pkg::wr_req_t     wr,
  output irqt_pkg::step_t       status
);

  irqt_pkg::col_t       x_r, x_nxt;
  irqt_pkg::row_t       y_r, y_nxt;
  irqt_pkg::bank_addr_t ridx_r, ridx_nxt;
  logic                 wbank_r, wbank_nxt;
  logic                 fready_r, fready_nxt;

  logic                 s1_v_r;
  irqt_pkg::prod_t      s1_prod_r;
  irqt_pkg::opa_t       s1_add_r;
  irqt_pkg::pixel_t     s1_pix_r;
  logic                 s1_bank_r;

  logic                 x_end, y_end, last;
  irqt_pkg::opa_t       opa, addend, x_flip, y_flip;
  irqt_pkg::opb_t       opb;
  irqt_pkg::prod_t      sum;

  // End of row and end of frame for the pixel now at the input.
  assign x_end = (irqt_pkg::width_t'(x_r) + irqt_pkg::width_t'(1)) >= width;
  assign y_end = (irqt_pkg::height_t'(y_r) + irqt_pkg::height_t'(1)) >= height;
  assign last  = x_end && y_end;

  // Mirrored coordinates W-1-x and H-1-y.
  assign x_flip = irqt_pkg::opa_t'(width - irqt_pkg::width_t'(1) - irqt_pkg::width_t'(x_r));
  assign y_flip = irqt_pkg::opa_t'(height - irqt_pkg::height_t'(1)
                                   - irqt_pkg::height_t'(y_r));

  // Destination index = opa * opb + addend, chosen by the rotation.
  always_comb begin
    unique case (turns)
      irqt_pkg::TURN_90: begin
        opa    = irqt_pkg::opa_t'(x_r);
        opb    = irqt_pkg::opb_t'(height);
        addend = y_flip;
      end
      irqt_pkg::TURN_180: begin
        opa    = y_flip;
        opb    = irqt_pkg::opb_t'(width);
        addend = x_flip;
      end
      irqt_pkg::TURN_270: begin
        opa    = x_flip;
        opb    = irqt_pkg::opb_t'(height);
        addend = irqt_pkg::opa_t'(y_r);
      end
      default: begin
        opa    = irqt_pkg::opa_t'(y_r);
        opb    = irqt_pkg::opb_t'(width);
        addend = irqt_pkg::opa_t'(x_r);
      end
    endcase
  end

  // Counter and bank updates for an accepted item or a geometry write.
  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    ridx_nxt   = ridx_r;
    wbank_nxt  = wbank_r;
    fready_nxt = fready_r;
    if (geom_clear) begin
      x_nxt    = '0;
      y_nxt    = '0;
      ridx_nxt = '0;
    end else if (accept) begin
      if (last) begin
        x_nxt      = '0;
        y_nxt      = '0;
        ridx_nxt   = '0;
        wbank_nxt  = ~wbank_r;
        fready_nxt = 1'b1;
      end else begin
        ridx_nxt = ridx_r + irqt_pkg::bank_addr_t'(1);
        if (x_end) begin
          x_nxt = '0;
          y_nxt = y_r + irqt_pkg::row_t'(1);
        end else begin
          x_nxt = x_r + irqt_pkg::col_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      ridx_r   <= '0;
      wbank_r  <= 1'b0;
      fready_r <= 1'b0;
      s1_v_r   <= 1'b0;
    end else begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      ridx_r   <= ridx_nxt;
      wbank_r  <= wbank_nxt;
      fready_r <= fready_nxt;
      s1_v_r   <= accept;
    end
  end

  // First stage: register the product and the operands of the final add.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r <= irqt_pkg::prod_t'(opa) * irqt_pkg::prod_t'(opb);
      s1_add_r  <= addend;
      s1_pix_r  <= pixel;
      s1_bank_r <= wbank_r;
    end
  end

  // Second stage: finish the address and write into the frame store.
  assign sum = s1_prod_r + irqt_pkg::prod_t'(s1_add_r);

  assign wr.en   = s1_v_r;
  assign wr.addr = {s1_bank_r, sum[irqt_pkg::BANK_AW-1:0]};
  assign wr.data = s1_pix_r;

  // Previous frame is read in raster order from the other bank.
  assign rd_addr = {~wbank_r, ridx_r};

  assign status.frame_ready = fready_r;
  assign status.last        = last;
  assign status.write_bank  = wbank_r;

endmodule

// File: rtl/image_rotate_quarter_turns.sv
// Top level of the quarter-turn image rotator with a ping-pong frame store.
//
// Usage:
//   in_px carries one pixel per item in raster order; out_px returns one
//   result item per input item: the pixel of the previous frame at the same
//   raster position after rotation, a flag that a full frame is stored, and
//   a frame end marker on the last pixel of the incoming frame.
//   Configuration must be written on cfg_we/cfg_idx/cfg_data only while
//   no item is in flight; the block does not enforce this. Index 0 sets
//   the quarter turns, 1 the width, 2 the height. Writing width or height
//   restarts the current frame. Throughput is one item per clock while
//   the receiver takes results. A result appears in the cycle after its
//   item is accepted. The rotated write registers the product, then adds
//   and writes; a same-cycle read of that entry is forwarded.
//   Reset clears the counters, selects bank 0, marks the output not valid
//   and restores 0 turns and 256 x 256. The store itself is not cleared.
//   When the receiver stalls, the result holds in the output register and
//   in_px.ready drops until it is taken.
`include "image_rotate_quarter_turns_macros.svh"

module image_rotate_quarter_turns (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  irqt_pkg::cfg_idx_t cfg_idx,
  input  irqt_pkg::cfg_data_t cfg_data,
  irqt_in_if.sink            in_px,
  irqt_out_if.source         out_px
);

  irqt_pkg::turns_t      turns_r;
  irqt_pkg::width_t      width_r;
  irqt_pkg::height_t     height_r;
  logic                  geom_clear;

  logic                  in_ready;
  logic                  accept;
  logic                  out_v_r, ovalid_r, oend_r;

  irqt_pkg::store_addr_t rd_addr;
  irqt_pkg::wr_req_t     wr;
  irqt_pkg::step_t       status;
  irqt_pkg::pixel_t      rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turns_r  <= irqt_pkg::TURN_0;
      width_r  <= irqt_pkg::WIDTH_RST;
      height_r <= irqt_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        irqt_pkg::REG_TURNS:  turns_r  <= irqt_pkg::turns_t'(cfg_data[1:0]);
        irqt_pkg::REG_WIDTH:  width_r  <= irqt_pkg::clamp_width(cfg_data);
        irqt_pkg::REG_HEIGHT: height_r <= irqt_pkg::clamp_height(cfg_data);
        default: ;
      endcase
    end
  end

  assign geom_clear = cfg_we && ((cfg_idx == irqt_pkg::REG_WIDTH) ||
                                 (cfg_idx == irqt_pkg::REG_HEIGHT));

  // Input is taken whenever the output register is free or being emptied.
  assign in_ready     = !out_v_r || out_px.ready;
  assign in_px.ready  = in_ready;
  assign accept       = in_px.valid && in_ready;

  irqt_addr_gen u_addr_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pixel      (irqt_pkg::pixel_t'(in_px.pixel_in)),
    .turns      (turns_r),
    .width      (width_r),
    .height     (height_r),
    .geom_clear (geom_clear),
    .rd_addr    (rd_addr),
    .wr         (wr),
    .status     (status)
  );

  irqt_frame_ram u_frame_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register; the pixel itself sits in the store's read register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (accept) begin
      out_v_r <= 1'b1;
    end else if (out_px.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ovalid_r <= status.frame_ready;
      oend_r   <= status.last;
    end
  end

  assign out_px.valid     = out_v_r;
  assign out_px.pixel_out = ovalid_r ? irqt_pkg::field_t'(rd_data) : '0;
  assign out_px.out_valid = ovalid_r;
  assign out_px.frame_end = oend_r;

  // Checks on the bank swap, the ready flag and the output register.
  `IRQT_ASSERT_NEXT(a_bank_swap, accept && status.last, status.write_bank != $past(status.write_bank))
  `IRQT_ASSERT_NEXT(a_ready_sticky, status.frame_ready, status.frame_ready)
  `IRQT_ASSERT_NEXT(a_accept_fills, accept, out_v_r)
  `IRQT_ASSERT_NOW(a_zero_invalid, out_v_r && !ovalid_r, out_px.pixel_out == '0)

endmodule
